### hdl/viewport_tile_fetch_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the viewport tile fetch scheduler
// Concurrent checks sampled on clk and idle while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIEWPORT_TILE_FETCH_SCHEDULER_CORE_MACROS_SVH
`define VIEWPORT_TILE_FETCH_SCHEDULER_CORE_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds
`define VTFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds
`define VTFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vtfs_pkg.sv
// ----------------------------------------------------------------------------
// vtfs_pkg
// Types and constants shared by the tile fetch scheduler modules.
// ----------------------------------------------------------------------------
package vtfs_pkg;

  // Grid geometry
  localparam int TILE_SHIFT   = 9;      // base tile is 512 pixels
  localparam int MAX_TILES    = 128;    // tiles per side per level
  localparam int MAX_BATCH    = 64;     // tiles per update
  localparam int LOD_LEVELS   = 5;

  localparam int COL_W        = 7;      // tile column / row index
  localparam int GRID_W       = 8;      // grid edge, 0..MAX_TILES
  localparam int LOD_W        = 3;
  localparam int SH_W         = 4;      // tile size shift amount
  localparam int TS_W         = 14;     // tile size in pixels
  localparam int EDGE_W       = 19;     // signed viewport edge
  localparam int CEN_W        = 19;     // signed doubled viewport centre
  localparam int DEN_W        = 20;     // priority denominator
  localparam int DIST_W       = 24;     // half-pixel Manhattan distance
  localparam int NUM_W        = 31;     // distance times 99
  localparam int Q_W          = 9;      // quotient bits incl. saturation
  localparam int CNT_W        = 7;      // pending count 0..MAX_BATCH
  localparam int SIZE_W       = 14;     // src / dst sizes

  // Status store: one row of all columns per (level, row)
  localparam int MEM_ROWS     = LOD_LEVELS * MAX_TILES;
  localparam int MEM_AW       = LOD_W + COL_W;
  localparam int ROW_BITS     = 2 * MAX_TILES;

  // Tile status codes
  localparam logic [1:0] ST_IDLE       = 2'b00;
  localparam logic [1:0] ST_DISPATCHED = 2'b01;
  localparam logic [1:0] ST_READY      = 2'b10;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_PREVIEW_RATIO = 2'd2;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_DONE   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_DONE   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_kind_t;

  // Classified work handed from front to back
  typedef struct packed {
    cmd_kind_t               kind;
    logic [LOD_W-1:0]        lod;
    logic [GRID_W-1:0]       c0;
    logic [GRID_W-1:0]       c1;
    logic [GRID_W-1:0]       r0;
    logic [GRID_W-1:0]       r1;
    logic [CEN_W-1:0]        vcx2;
    logic [CEN_W-1:0]        vcy2;
    logic [DEN_W-1:0]        denom;
    logic [15:0]             scale;
    logic [COL_W-1:0]        done_col;
    logic [COL_W-1:0]        done_row;
  } cmd_t;

  // One pending tile in the sorted list
  typedef struct packed {
    logic [COL_W-1:0]        col;
    logic [COL_W-1:0]        row;
    logic [DIST_W-1:0]       mdist;
  } ent_t;

  // One result item
  typedef struct packed {
    logic [COL_W-1:0]        tile_col;
    logic [COL_W-1:0]        tile_row;
    logic [LOD_W-1:0]        tile_lod;
    logic [15:0]             src_x;
    logic [15:0]             src_y;
    logic [SIZE_W-1:0]       src_w;
    logic [SIZE_W-1:0]       src_h;
    logic [SIZE_W-1:0]       dst_w;
    logic [SIZE_W-1:0]       dst_h;
    logic [6:0]              prio;
    logic                    last;
  } res_t;

  typedef enum logic [3:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_ROW_RD,
    BS_ROW_LOAD,
    BS_SCAN,
    BS_ROW_WB,
    BS_DONE_RD,
    BS_DONE_WB,
    BS_E_PREP,
    BS_E_DIV,
    BS_E_OUT
  } back_state_t;

endpackage

### hdl/viewport_tile_fetch_scheduler_core.sv
// ----------------------------------------------------------------------------
// viewport_tile_fetch_scheduler_core
// Schedules tile fetches for a zoomable viewer, nearest tiles first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready   | in_tdata, in_tuser (op)
//  out_    | master    | out_tvalid/out_tready | out_tdata, out_tlast
//  cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// Items run one at a time through the back end; a two-entry queue lets the
// front take the next item meanwhile. An update is popped, then each covered
// grid row is read, loaded, scanned tile by tile and written back, then each
// emitted tile is prepared, run through the nine-step priority divider and
// output; a tile complete reads its row and writes it back. Reset and clear
// sweep all 640 status store rows one row a cycle, with in_tready low. Output
// stalls hold the emit sequence.
module viewport_tile_fetch_scheduler_core
  import vtfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // view_x[16:0] view_y[33:17] view_w[49:34] view_h[65:50] zoom_scale[81:66]
  // done_col[88:82] done_row[95:89] done_lod[98:96], zero fill above
  input  logic [103:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tile_col[6:0] tile_row[13:7] tile_lod[16:14] src_x[32:17] src_y[48:33]
  // src_w[62:49] src_h[76:63] dst_w[90:77] dst_h[104:91] priority_res[111:105]
  output logic [111:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

`include "viewport_tile_fetch_scheduler_core_macros.svh"

  logic [15:0] image_width_r;
  logic [15:0] image_height_r;
  logic [15:0] preview_ratio_r;
  logic        keep;
  cmd_t        front_cmd;
  logic        fifo_full;
  logic        fifo_valid;
  cmd_t        fifo_cmd;
  logic        fifo_pop;
  logic        clear_busy;
  res_t        out_item;
  logic        in_acc;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 16'd0;
      image_height_r  <= 16'd0;
      preview_ratio_r <= 16'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width_r   <= cfg_data;
        CFG_IMAGE_HEIGHT:  image_height_r  <= cfg_data;
        CFG_PREVIEW_RATIO: preview_ratio_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Accept an item while the queue has room and no sweep runs
  assign in_tready = !fifo_full && !clear_busy;
  assign in_acc    = in_tvalid && in_tready;

  vtfs_front u_front (
    .op            (in_tuser),
    .view_x        (in_tdata[16:0]),
    .view_y        (in_tdata[33:17]),
    .view_w        (in_tdata[49:34]),
    .view_h        (in_tdata[65:50]),
    .zoom_scale    (in_tdata[81:66]),
    .done_col      (in_tdata[88:82]),
    .done_row      (in_tdata[95:89]),
    .done_lod      (in_tdata[98:96]),
    .image_width   (image_width_r),
    .image_height  (image_height_r),
    .preview_ratio (preview_ratio_r),
    .keep          (keep),
    .cmd           (front_cmd)
  );

  vtfs_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc && keep),
    .din   (front_cmd),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .valid (fifo_valid),
    .dout  (fifo_cmd)
  );

  vtfs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (fifo_valid),
    .cmd          (fifo_cmd),
    .cmd_pop      (fifo_pop),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .clear_busy   (clear_busy),
    .out_valid    (out_tvalid),
    .out_item     (out_item),
    .out_ready    (out_tready)
  );

  // Pack the result item
  assign out_tdata = {out_item.prio, out_item.dst_h, out_item.dst_w, out_item.src_h,
                      out_item.src_w, out_item.src_y, out_item.src_x, out_item.tile_lod,
                      out_item.tile_row, out_item.tile_col};
  assign out_tlast = out_item.last;

  // Checks
  `VTFS_ASSERT_SAME(a_prio_range, out_tvalid, (out_item.prio != 7'd0) && (out_item.prio <= 7'd100), "priority out of range")
  `VTFS_ASSERT_SAME(a_size_nonzero, out_tvalid, (out_item.src_w != '0) && (out_item.dst_w != '0) && (out_item.src_h != '0) && (out_item.dst_h != '0), "zero tile size")
  `VTFS_ASSERT_SAME(a_lod_range, out_tvalid, out_item.tile_lod < LOD_W'(LOD_LEVELS), "detail level out of range")
  `VTFS_ASSERT_NEXT(a_no_pop_in_sweep, clear_busy, !fifo_pop || !clear_busy, "queue popped during sweep")

endmodule

### hdl/vtfs_front.sv
// ----------------------------------------------------------------------------
// vtfs_front
// Classifies an incoming item: threshold test, detail level, clamped tile
// grid, viewport centre and priority denominator. Drops items with no effect.
// ----------------------------------------------------------------------------
module vtfs_front
  import vtfs_pkg::*;
(
  input  logic [1:0]          op,
  input  logic signed [16:0]  view_x,
  input  logic signed [16:0]  view_y,
  input  logic [15:0]         view_w,
  input  logic [15:0]         view_h,
  input  logic [15:0]         zoom_scale,
  input  logic [COL_W-1:0]    done_col,
  input  logic [COL_W-1:0]    done_row,
  input  logic [LOD_W-1:0]    done_lod,
  input  logic [15:0]         image_width,
  input  logic [15:0]         image_height,
  input  logic [15:0]         preview_ratio,
  output logic                keep,
  output cmd_t                cmd
);

  // Tile index of an edge, zero for edges at or left of zero, capped at lim
  function automatic logic [GRID_W-1:0] grid_edge(input logic signed [EDGE_W-1:0] v,
                                                  input logic [SH_W-1:0] sh,
                                                  input logic [GRID_W-1:0] lim);
    logic [EDGE_W-1:0] q;
    q = (v > 0) ? (EDGE_W'(v) >> sh) : '0;
    return (q > EDGE_W'(lim)) ? lim : q[GRID_W-1:0];
  endfunction

  function automatic logic [GRID_W-1:0] grid_count(input logic [15:0] size,
                                                   input logic [SH_W-1:0] sh,
                                                   input logic [TS_W-1:0] ts);
    logic [EDGE_W-1:0] q;
    q = (EDGE_W'(size) + EDGE_W'(ts) - EDGE_W'(1)) >> sh;
    return (q > EDGE_W'(MAX_TILES)) ? GRID_W'(MAX_TILES) : q[GRID_W-1:0];
  endfunction

  logic [22:0]              thr_lhs;
  logic [22:0]              thr_rhs;
  logic                     active;
  logic [LOD_W-1:0]         lod;
  logic [SH_W-1:0]          sh;
  logic [TS_W-1:0]          ts;
  logic [GRID_W-1:0]        max_c;
  logic [GRID_W-1:0]        max_r;
  logic signed [EDGE_W-1:0] vx_e;
  logic signed [EDGE_W-1:0] vy_e;
  logic signed [EDGE_W-1:0] ce;
  logic signed [EDGE_W-1:0] re;
  logic [GRID_W-1:0]        c0;
  logic [GRID_W-1:0]        c1;
  logic [GRID_W-1:0]        r0;
  logic [GRID_W-1:0]        r1;

  // Threshold: scale * 100 > preview_ratio * 101, exact
  assign thr_lhs = 23'(zoom_scale) * 23'd100;
  assign thr_rhs = 23'(preview_ratio) * 23'd101;
  assign active  = (image_width != '0) && (image_height != '0) && (thr_lhs > thr_rhs);

  // Pick the detail level from the scale
  always_comb begin
    if (zoom_scale >= 16'd4096)      lod = LOD_W'(0);
    else if (zoom_scale >= 16'd2048) lod = LOD_W'(1);
    else if (zoom_scale >= 16'd1024) lod = LOD_W'(2);
    else if (zoom_scale >= 16'd512)  lod = LOD_W'(3);
    else                             lod = LOD_W'(4);
    if (lod > LOD_W'(LOD_LEVELS - 1)) lod = LOD_W'(LOD_LEVELS - 1);
  end

  assign sh = SH_W'(TILE_SHIFT) + SH_W'(lod);
  assign ts = TS_W'(1) << sh;

  // Clamp the covered grid to the image
  assign max_c = grid_count(image_width, sh, ts);
  assign max_r = grid_count(image_height, sh, ts);
  assign vx_e  = EDGE_W'(view_x);
  assign vy_e  = EDGE_W'(view_y);
  assign ce    = vx_e + $signed(EDGE_W'(view_w)) + $signed(EDGE_W'(ts)) - EDGE_W'(1);
  assign re    = vy_e + $signed(EDGE_W'(view_h)) + $signed(EDGE_W'(ts)) - EDGE_W'(1);
  assign c0    = grid_edge(vx_e, sh, max_c);
  assign r0    = grid_edge(vy_e, sh, max_r);
  assign c1    = grid_edge(ce, sh, max_c);
  assign r1    = grid_edge(re, sh, max_r);

  // Build the command
  always_comb begin
    cmd.kind     = CMD_UPDATE;
    cmd.lod      = lod;
    cmd.c0       = c0;
    cmd.c1       = c1;
    cmd.r0       = r0;
    cmd.r1       = r1;
    cmd.vcx2     = CEN_W'(vx_e + vx_e + $signed(EDGE_W'(view_w)));
    cmd.vcy2     = CEN_W'(vy_e + vy_e + $signed(EDGE_W'(view_h)));
    cmd.denom    = DEN_W'(3) * (DEN_W'(view_w) + DEN_W'(view_h)) + DEN_W'(2);
    cmd.scale    = zoom_scale;
    cmd.done_col = done_col;
    cmd.done_row = done_row;
    keep         = 1'b0;
    unique case (op_t'(op))
      OP_UPDATE: begin
        keep = active && (c0 < c1) && (r0 < r1);
      end
      OP_DONE: begin
        // column and row always fit the grid; only the level is checked
        cmd.kind = CMD_DONE;
        cmd.lod  = done_lod;
        keep     = done_lod < LOD_W'(LOD_LEVELS);
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

### hdl/vtfs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// vtfs_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module vtfs_cmd_fifo
  import vtfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t dout
);

  cmd_t       mem_r [0:1];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign dout  = mem_r[rptr_r];

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/vtfs_sort_list.sv
// ----------------------------------------------------------------------------
// vtfs_sort_list
// Row of cells holding pending tiles sorted by distance. An insert lands
// behind every entry of equal or smaller distance; a pop shifts all down.
// ----------------------------------------------------------------------------
module vtfs_sort_list
  import vtfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             ins,
  input  ent_t             ins_ent,
  input  logic             pop,
  output ent_t             head,
  output logic [CNT_W-1:0] count
);

  ent_t             cell_r [0:MAX_BATCH-1];
  logic [CNT_W-1:0] count_r;
  logic             stay [0:MAX_BATCH-1];

  assign head  = cell_r[0];
  assign count = count_r;

  // Mark cells that keep their entry on insert
  always_comb begin
    for (int i = 0; i < MAX_BATCH; i++) begin
      stay[i] = (CNT_W'(i) < count_r) && (cell_r[i].mdist <= ins_ent.mdist);
    end
  end

  // Insert or shift the cells
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BATCH; i++) begin
      if (ins) begin
        if (!stay[i]) begin
          if (i == 0) begin
            cell_r[i] <= ins_ent;
          end else if (stay[i-1]) begin
            cell_r[i] <= ins_ent;
          end else begin
            cell_r[i] <= cell_r[i-1];
          end
        end
      end else if (pop && (i < MAX_BATCH - 1)) begin
        cell_r[i] <= cell_r[i+1];
      end
    end
  end

  // Track the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clear) begin
      count_r <= '0;
    end else if (ins) begin
      count_r <= count_r + CNT_W'(1);
    end else if (pop) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

### hdl/vtfs_back.sv
// ----------------------------------------------------------------------------
// vtfs_back
// Carries out commands: status store sweeps, grid scan with sorted insert,
// and per-tile result build with an iterative priority divider.
// ----------------------------------------------------------------------------
module vtfs_back
  import vtfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  output logic        clear_busy,
  output logic        out_valid,
  output res_t        out_item,
  input  logic        out_ready
);

  function automatic logic [SIZE_W-1:0] dst_clip(input logic [29:0] p);
    logic [17:0] d;
    d = p[29:12];
    if (d == '0) return SIZE_W'(1);
    if (d > 18'd8192) return SIZE_W'(8192);
    return d[SIZE_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] half_dist(input logic [GRID_W-1:0] idx,
                                                  input logic [SH_W-1:0] sh,
                                                  input logic [CEN_W-1:0] cen2);
    logic [DIST_W-1:0]        t;
    logic signed [DIST_W-1:0] d;
    t = DIST_W'({idx, 1'b0} + 9'd1) << sh;
    d = $signed(t) - $signed({{(DIST_W-CEN_W){cen2[CEN_W-1]}}, cen2});
    return d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
  endfunction

  back_state_t         state_r;
  back_state_t         state_nxt;
  cmd_t                cmd_r;
  logic [MEM_AW-1:0]   clr_addr_r;
  logic [GRID_W-1:0]   row_r;
  logic [GRID_W-1:0]   col_r;
  logic [ROW_BITS-1:0] row_buf_r;
  logic [ROW_BITS-1:0] rd_data_r;
  logic [ROW_BITS-1:0] mem [0:MEM_ROWS-1];
  logic [DIST_W-1:0]   dy_r;
  logic [NUM_W-1:0]    rem_r;
  logic [NUM_W-1:0]    dsh_r;
  logic [Q_W-1:0]      q_r;
  logic [3:0]          step_r;
  logic [SIZE_W-1:0]   sw_r;
  logic [SIZE_W-1:0]   sh_r;
  logic [SIZE_W-1:0]   dstw_r;
  logic [SIZE_W-1:0]   dsth_r;
  logic [15:0]         sx_r;
  logic [15:0]         sy_r;
  logic [COL_W-1:0]    ecol_r;
  logic [COL_W-1:0]    erow_r;
  logic                out_valid_r;
  res_t                out_item_r;

  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;
  logic [MEM_AW-1:0]   mem_raddr;
  logic                list_clear;
  logic                list_ins;
  logic                list_pop;
  logic                out_load;
  ent_t                ins_ent;
  ent_t                head;
  logic [CNT_W-1:0]    cnt;
  logic [SH_W-1:0]     sh;
  logic [TS_W-1:0]     ts;
  logic [1:0]          scan_st;
  logic                take;
  logic                scan_end;
  logic [ROW_BITS-1:0] done_row_mod;
  logic [19:0]         sx_full;
  logic [19:0]         sy_full;
  logic                ge;
  logic [29:0]         prod;
  logic [6:0]          prio;

  assign sh      = SH_W'(TILE_SHIFT) + SH_W'(cmd_r.lod);
  assign ts      = TS_W'(1) << sh;
  assign scan_st = row_buf_r[{col_r[COL_W-1:0], 1'b0} +: 2];
  assign take    = scan_st == ST_IDLE;
  assign scan_end = (col_r + GRID_W'(1) == cmd_r.c1) ||
                    (cnt + CNT_W'(take) == CNT_W'(MAX_BATCH));

  // Candidate for the sorted list
  assign ins_ent.col   = col_r[COL_W-1:0];
  assign ins_ent.row   = row_r[COL_W-1:0];
  assign ins_ent.mdist = half_dist(col_r, sh, cmd_r.vcx2) + dy_r;

  // Mark the completed tile ready
  always_comb begin
    done_row_mod = rd_data_r;
    done_row_mod[{cmd_r.done_col, 1'b0} +: 2] = ST_READY;
  end

  // Result geometry of the head tile
  assign sx_full = 20'(head.col) << sh;
  assign sy_full = 20'(head.row) << sh;

  // Divider step and shared size multiplier
  assign ge   = rem_r >= dsh_r;
  assign prod = 30'((step_r == 4'd0) ? sw_r : sh_r) * 30'(cmd_r.scale);
  assign prio = (q_r >= Q_W'(99)) ? 7'd1 : 7'(Q_W'(100) - q_r);

  vtfs_sort_list u_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (list_clear),
    .ins     (list_ins),
    .ins_ent (ins_ent),
    .pop     (list_pop),
    .head    (head),
    .count   (cnt)
  );

  // Status store: one row write and one registered row read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and control
  always_comb begin
    state_nxt  = state_r;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = {cmd_r.lod, row_r[COL_W-1:0]};
    mem_wdata  = row_buf_r;
    mem_raddr  = {cmd_r.lod, row_r[COL_W-1:0]};
    list_clear = 1'b0;
    list_ins   = 1'b0;
    list_pop   = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      BS_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == MEM_AW'(MEM_ROWS - 1)) state_nxt = BS_IDLE;
      end
      BS_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_CLEAR: state_nxt = BS_CLEAR;
            CMD_DONE:  state_nxt = BS_DONE_RD;
            default: begin
              list_clear = 1'b1;
              state_nxt  = BS_ROW_RD;
            end
          endcase
        end
      end
      BS_ROW_RD: begin
        state_nxt = BS_ROW_LOAD;
      end
      BS_ROW_LOAD: begin
        state_nxt = BS_SCAN;
      end
      BS_SCAN: begin
        list_ins = take;
        if (scan_end) state_nxt = BS_ROW_WB;
      end
      BS_ROW_WB: begin
        mem_we = 1'b1;
        if ((cnt == CNT_W'(MAX_BATCH)) || (row_r + GRID_W'(1) == cmd_r.r1)) begin
          state_nxt = (cnt == '0) ? BS_IDLE : BS_E_PREP;
        end else begin
          state_nxt = BS_ROW_RD;
        end
      end
      BS_DONE_RD: begin
        mem_raddr = {cmd_r.lod, cmd_r.done_row};
        state_nxt = BS_DONE_WB;
      end
      BS_DONE_WB: begin
        mem_we    = 1'b1;
        mem_waddr = {cmd_r.lod, cmd_r.done_row};
        mem_wdata = done_row_mod;
        state_nxt = BS_IDLE;
      end
      BS_E_PREP: begin
        state_nxt = BS_E_DIV;
      end
      BS_E_DIV: begin
        if (step_r == 4'(Q_W - 1)) state_nxt = BS_E_OUT;
      end
      BS_E_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          list_pop  = 1'b1;
          state_nxt = (cnt == CNT_W'(1)) ? BS_IDLE : BS_E_PREP;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  // Sweep address for the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (state_r == BS_CLEAR) begin
      clr_addr_r <= (clr_addr_r == MEM_AW'(MEM_ROWS - 1)) ? '0 : clr_addr_r + MEM_AW'(1);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: begin
        if (cmd_valid) begin
          cmd_r <= cmd;
          row_r <= cmd.r0;
        end
      end
      BS_ROW_LOAD: begin
        row_buf_r <= rd_data_r;
        col_r     <= cmd_r.c0;
        dy_r      <= half_dist(row_r, sh, cmd_r.vcy2);
      end
      BS_SCAN: begin
        if (take) row_buf_r[{col_r[COL_W-1:0], 1'b0} +: 2] <= ST_DISPATCHED;
        col_r <= col_r + GRID_W'(1);
      end
      BS_ROW_WB: begin
        row_r <= row_r + GRID_W'(1);
      end
      BS_E_PREP: begin
        ecol_r <= head.col;
        erow_r <= head.row;
        sx_r   <= sx_full[15:0];
        sy_r   <= sy_full[15:0];
        sw_r   <= ((21'(sx_full) + 21'(ts)) > 21'(image_width)) ?
                  SIZE_W'(20'(image_width) - sx_full) : SIZE_W'(ts);
        sh_r   <= ((21'(sy_full) + 21'(ts)) > 21'(image_height)) ?
                  SIZE_W'(20'(image_height) - sy_full) : SIZE_W'(ts);
        rem_r  <= NUM_W'(head.mdist) * NUM_W'(99);
        dsh_r  <= NUM_W'({cmd_r.denom, 8'b0});
        q_r    <= '0;
        step_r <= '0;
      end
      BS_E_DIV: begin
        if (ge) rem_r <= rem_r - dsh_r;
        dsh_r  <= dsh_r >> 1;
        q_r    <= {q_r[Q_W-2:0], ge};
        step_r <= step_r + 4'd1;
        if (step_r == 4'd0) dstw_r <= dst_clip(prod);
        if (step_r == 4'd1) dsth_r <= dst_clip(prod);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.tile_col <= ecol_r;
      out_item_r.tile_row <= erow_r;
      out_item_r.tile_lod <= cmd_r.lod;
      out_item_r.src_x    <= sx_r;
      out_item_r.src_y    <= sy_r;
      out_item_r.src_w    <= sw_r;
      out_item_r.src_h    <= sh_r;
      out_item_r.dst_w    <= dstw_r;
      out_item_r.dst_h    <= dsth_r;
      out_item_r.prio     <= prio;
      out_item_r.last     <= cnt == CNT_W'(1);
    end
  end

  assign clear_busy = state_r == BS_CLEAR;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

endmodule

### bench/tb_viewport_tile_fetch_scheduler_core.sv
// ----------------------------------------------------------------------------
// Tile fetch scheduler testbench
// Drives viewport updates, tile completions and clears with random gaps on
// both streams, predicts every dispatched tile from a local status store and
// compares each result field by field. Registers are written between phases.
// ----------------------------------------------------------------------------
module tb_viewport_tile_fetch_scheduler_core;
  import vtfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t         op;
    logic [16:0] vx;
    logic [16:0] vy;
    logic [15:0] vw;
    logic [15:0] vh;
    logic [15:0] scale;
    logic [6:0]  dcol;
    logic [6:0]  drow;
    logic [2:0]  dlod;
  } req_t;

  // directed row: request plus an optional typed-in expected tile count
  typedef struct {
    req_t req;
    int   tiles;  // -1 means predicted only
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  // predictor state
  logic [1:0]  tile_state [LOD_LEVELS][MAX_TILES][MAX_TILES];
  logic [15:0] img_w, img_h, prev_ratio;
  res_t        tile_queue [$];
  row_t        dir [$];
  int          errors;
  logic        out_ready_ena;

  viewport_tile_fetch_scheduler_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #1s;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint dist2(longint c, longint r, longint ts, longint vx,
                                   longint vy, longint vw, longint vh);
    longint dx, dy;
    dx = (2 * c + 1) * ts - (2 * vx + vw);
    dy = (2 * r + 1) * ts - (2 * vy + vh);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx + dy;
  endfunction

  function automatic longint scaled(longint s, longint sc);
    longint d;
    d = (s * sc) >>> 12;
    if (d < 1) d = 1;
    if (d > 8192) d = 8192;
    return d;
  endfunction

  function automatic longint edge_tile(longint e, longint ts, longint mx);
    longint t;
    t = (e > 0) ? e / ts : 0;
    return (t > mx) ? mx : t;
  endfunction

  // advance the predictor by one request, queue the tiles it dispatches
  function automatic int predict_tiles(req_t q);
    longint vx, vy, vw, vh, sc, ts, mxc, mxr, c0, c1, r0, r1, den, d, qq;
    longint sx, sy, sw, sh;
    int     lod, n, j, cc, rr;
    int     pc [$];
    int     pr [$];
    longint pd [$];
    res_t   t;
    if (q.op == OP_DONE) begin
      if (q.dlod < LOD_LEVELS) tile_state[q.dlod][q.drow][q.dcol] = ST_READY;
      return 0;
    end
    if (q.op == OP_CLEAR) begin
      foreach (tile_state[a, b, c]) tile_state[a][b][c] = ST_IDLE;
      return 0;
    end
    if (q.op != OP_UPDATE) return 0;
    vx = $signed(q.vx);
    vy = $signed(q.vy);
    vw = q.vw;
    vh = q.vh;
    sc = q.scale;
    if (img_w == 0 || img_h == 0) return 0;
    if (sc * 100 <= longint'(prev_ratio) * 101) return 0;
    lod = (sc >= 4096) ? 0 : (sc >= 2048) ? 1 : (sc >= 1024) ? 2 : (sc >= 512) ? 3 : 4;
    ts = longint'(512) << lod;
    mxc = (img_w + ts - 1) / ts;
    mxr = (img_h + ts - 1) / ts;
    if (mxc > MAX_TILES) mxc = MAX_TILES;
    if (mxr > MAX_TILES) mxr = MAX_TILES;
    c0 = edge_tile(vx, ts, mxc);
    r0 = edge_tile(vy, ts, mxr);
    c1 = edge_tile(vx + vw + ts - 1, ts, mxc);
    r1 = edge_tile(vy + vh + ts - 1, ts, mxr);
    for (longint r = r0; r < r1 && pc.size() < MAX_BATCH; r++)
      for (longint c = c0; c < c1 && pc.size() < MAX_BATCH; c++)
        if (tile_state[lod][r][c] == ST_IDLE) begin
          tile_state[lod][r][c] = ST_DISPATCHED;
          // stable insert: after every entry of equal or smaller distance
          d = dist2(c, r, ts, vx, vy, vw, vh);
          j = pc.size();
          while (j > 0 && pd[j-1] > d) j--;
          pc.insert(j, int'(c));
          pr.insert(j, int'(r));
          pd.insert(j, d);
        end
    n = pc.size();
    den = 3 * (vw + vh) + 2;
    for (int k = 0; k < n; k++) begin
      cc = pc[k];
      rr = pr[k];
      sx = cc * ts;
      sy = rr * ts;
      sw = ts;
      sh = ts;
      if (sx + sw > img_w) sw = img_w - sx;
      if (sy + sh > img_h) sh = img_h - sy;
      qq = pd[k] * 99 / den;
      t.tile_col = cc[6:0];
      t.tile_row = rr[6:0];
      t.tile_lod = lod[2:0];
      t.src_x = sx[15:0];
      t.src_y = sy[15:0];
      t.src_w = sw[13:0];
      t.src_h = sh[13:0];
      t.dst_w = 14'(scaled(sw, sc));
      t.dst_h = 14'(scaled(sh, sc));
      t.prio = (qq >= 99) ? 7'd1 : 7'(100 - qq);
      t.last = (k == n - 1);
      tile_queue.insert(tile_queue.size(), t);
    end
    return n;
  endfunction

  function automatic req_t mk(op_t op, int vx, int vy, int vw, int vh, int sc);
    req_t q;
    q.op = op;
    q.vx = vx[16:0];
    q.vy = vy[16:0];
    q.vw = vw[15:0];
    q.vh = vh[15:0];
    q.scale = sc[15:0];
    q.dcol = 7'($urandom);
    q.drow = 7'($urandom);
    q.dlod = 3'($urandom);
    return q;
  endfunction

  function automatic req_t mk_done(int c, int r, int l);
    req_t q;
    q = mk(OP_DONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    q.dcol = c[6:0];
    q.drow = r[6:0];
    q.dlod = l[2:0];
    return q;
  endfunction

  // append one directed row
  function automatic void add_row(req_t q, int tiles);
    row_t e;
    e.req = q;
    e.tiles = tiles;
    dir.insert(dir.size(), e);
  endfunction

  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  task automatic send(req_t q);
    if ($urandom_range(0, 2) != 0) gap();
    in_tvalid <= 1'b1;
    in_tuser  <= q.op;
    in_tdata  <= {5'd0, q.dlod, q.drow, q.dcol, q.scale, q.vh, q.vw, q.vy, q.vx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all tiles and an idle block before touching registers
  task automatic drain();
    while (tile_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (!(dut.u_back.state_r == BS_IDLE && !dut.fifo_valid && !out_tvalid))
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) img_w = val;
    else if (idx == CFG_IMAGE_HEIGHT) img_h = val;
    else prev_ratio = val;
  endtask

  task automatic set_image(int w, int h, int pr);
    drain();
    write_reg(CFG_IMAGE_WIDTH, w[15:0]);
    write_reg(CFG_IMAGE_HEIGHT, h[15:0]);
    write_reg(CFG_PREVIEW_RATIO, pr[15:0]);
  endtask

  // result checker
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.tile_col = out_tdata[6:0];
      got.tile_row = out_tdata[13:7];
      got.tile_lod = out_tdata[16:14];
      got.src_x    = out_tdata[32:17];
      got.src_y    = out_tdata[48:33];
      got.src_w    = out_tdata[62:49];
      got.src_h    = out_tdata[76:63];
      got.dst_w    = out_tdata[90:77];
      got.dst_h    = out_tdata[104:91];
      got.prio     = out_tdata[111:105];
      got.last     = out_tlast;
      if (tile_queue.size() == 0) begin
        $error("unexpected tile col=%0d row=%0d", got.tile_col, got.tile_row);
        errors++;
      end else begin
        want = tile_queue.pop_front();
        if (got.tile_col !== want.tile_col) begin
          $error("tile_col exp %0d got %0d", want.tile_col, got.tile_col); errors++;
        end
        if (got.tile_row !== want.tile_row) begin
          $error("tile_row exp %0d got %0d", want.tile_row, got.tile_row); errors++;
        end
        if (got.tile_lod !== want.tile_lod) begin
          $error("tile_lod exp %0d got %0d", want.tile_lod, got.tile_lod); errors++;
        end
        if (got.src_x !== want.src_x) begin
          $error("src_x exp %0d got %0d", want.src_x, got.src_x); errors++;
        end
        if (got.src_y !== want.src_y) begin
          $error("src_y exp %0d got %0d", want.src_y, got.src_y); errors++;
        end
        if (got.src_w !== want.src_w) begin
          $error("src_w exp %0d got %0d", want.src_w, got.src_w); errors++;
        end
        if (got.src_h !== want.src_h) begin
          $error("src_h exp %0d got %0d", want.src_h, got.src_h); errors++;
        end
        if (got.dst_w !== want.dst_w) begin
          $error("dst_w exp %0d got %0d", want.dst_w, got.dst_w); errors++;
        end
        if (got.dst_h !== want.dst_h) begin
          $error("dst_h exp %0d got %0d", want.dst_h, got.dst_h); errors++;
        end
        if (got.prio !== want.prio) begin
          $error("priority_res exp %0d got %0d", want.prio, got.prio); errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last exp %0d got %0d", want.last, out_tlast); errors++;
        end
      end
    end
  end

  // random receiver stalls, with quiet stretches
  always @(posedge clk) begin
    if (!out_ready_ena) out_tready <= 1'b1;
    else if ($urandom_range(0, 199) == 0) out_tready <= 1'b0;
    else if (!out_tready) out_tready <= ($urandom_range(0, 7) == 0);
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    req_t   q;
    int     n, seq;
    int     sizes [3];
    errors = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b1;
    out_ready_ena = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    img_w = 0;
    img_h = 0;
    prev_ratio = 4096;
    foreach (tile_state[a, b, c]) tile_state[a][b][c] = ST_IDLE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no image loaded after reset: nothing comes out
    add_row(mk(OP_UPDATE, 0, 0, 1000, 1000, 16'hFFFF), 0);
    add_row(mk(OP_UPDATE, 0, 0, 1000, 1000, 8192), 0);
    foreach (dir[i]) begin
      n = predict_tiles(dir[i].req);
      if (dir[i].tiles >= 0 && n != dir[i].tiles) begin
        $error("tile count exp %0d got %0d", dir[i].tiles, n); errors++;
      end
      send(dir[i].req);
    end
    out_ready_ena = 1'b1;

    set_image(2000, 1500, 4096);
    dir.delete();
    // threshold: just below 1.01x is rejected, one step above passes
    add_row(mk(OP_UPDATE, 0, 0, 2000, 1500, 4136), 0);
    add_row(mk(OP_UPDATE, 0, 0, 2000, 1500, 4137), 12);
    add_row(mk(OP_UPDATE, 0, 0, 2000, 1500, 8000), 0);
    add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0), 0);
    add_row(mk_done(1, 1, 0), 0);
    add_row(mk_done(127, 127, 7), 0);
    add_row(mk_done(0, 0, 5), 0);
    add_row(mk(OP_UPDATE, 600, 600, 300, 300, 65535), -1);
    add_row(mk(op_t'(2'd3), 0, 0, 2000, 1500, 65535), 0);
    add_row(mk(OP_UPDATE, -65536, -65536, 65535, 65535, 65535), -1);
    add_row(mk(OP_UPDATE, 65535, 65535, 65535, 65535, 65535), 0);
    add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0), 0);
    add_row(mk(OP_UPDATE, 100, 100, 0, 0, 4200), -1);
    foreach (dir[i]) begin
      n = predict_tiles(dir[i].req);
      if (dir[i].tiles >= 0 && n != dir[i].tiles) begin
        $error("tile count exp %0d got %0d", dir[i].tiles, n); errors++;
      end
      send(dir[i].req);
    end

    // lower ratio for every level of detail, then the full batch limit
    set_image(65535, 65535, 0);
    for (int s = 0; s < 5; s++) begin
      q = mk(OP_UPDATE, 0, 0, 3000, 3000, 4096 >> s);
      void'(predict_tiles(q));
      send(q);
    end
    q = mk(OP_UPDATE, -5, -5, 65535, 65535, 4096);
    void'(predict_tiles(q));
    send(q);
    q = mk(OP_UPDATE, 0, 0, 0, 0, 0);
    void'(predict_tiles(q));
    send(q);

    // pause the sender until everything has drained
    while (tile_queue.size() != 0) @(posedge clk);

    // random phases over several image settings
    sizes = '{1, 2, 4};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_image(5000, 3000, 2048);
        1: set_image($urandom_range(1, 65535), $urandom_range(1, 65535), 65535);
        2: set_image($urandom_range(1, 8000), $urandom_range(1, 8000), $urandom_range(0, 600));
        default: set_image(65535, 65535, 4096);
      endcase
      for (int it = 0; it < 65; it++) begin
        seq = $urandom_range(0, 19);
        if (seq == 0) q = mk(OP_CLEAR, 0, 0, 0, 0, 0);
        else if (seq < 4) begin
          q = mk_done($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 4));
          if ($urandom_range(0, 4) == 0) q.dcol = 7'($urandom);
          if ($urandom_range(0, 4) == 0) q.drow = 7'($urandom);
          if ($urandom_range(0, 4) == 0) q.dlod = 3'($urandom);
        end else if (seq == 4) q = mk(op_t'(2'd3), $urandom, $urandom, $urandom,
                                      $urandom, $urandom);
        else if (seq == 5) q = mk(OP_UPDATE, $urandom, $urandom, $urandom, $urandom,
                                  $urandom);
        else q = mk(OP_UPDATE, $urandom_range(0, 6000) - 500, $urandom_range(0, 6000) - 500,
                    $urandom_range(0, 2500) * sizes[$urandom_range(0, 2)],
                    $urandom_range(0, 2500) * sizes[$urandom_range(0, 2)],
                    $urandom_range(256, 65535));
        void'(predict_tiles(q));
        send(q);
      end
    end

    // wait for the last tiles with a bound
    n = 0;
    while (tile_queue.size() != 0 && n < 2000000) begin
      @(posedge clk);
      n++;
    end
    repeat (1000) @(posedge clk);
    if (errors == 0 && tile_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
